// ----- rtl/core/point_to_box_border_hit_unit_assert.svh -----
`ifndef POINT_TO_BOX_BORDER_HIT_UNIT_ASSERT_SVH
`define POINT_TO_BOX_BORDER_HIT_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PBBH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbbh check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PBBH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbbh check failed");

`endif

// ----- rtl/core/pbbh_pkg.sv -----
package pbbh_pkg;

   localparam int COORD_BITS = 12;
   localparam int VW         = COORD_BITS + 1;
   localparam int PW         = 2 * COORD_BITS + 2;
   localparam int NUMW       = 2 * COORD_BITS + 3;
   localparam int NB         = 2 * COORD_BITS + 1;

   typedef enum logic [1:0] {
      SIDE_LEFT   = 2'd0,
      SIDE_RIGHT  = 2'd1,
      SIDE_TOP    = 2'd2,
      SIDE_BOTTOM = 2'd3
   } side_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic [COORD_BITS-1:0] box_left;
      logic [COORD_BITS-1:0] box_top;
      logic [COORD_BITS-1:0] box_right;
      logic [COORD_BITS-1:0] box_bottom;
   } req_item_type;

   typedef struct packed {
      side_type              side_crossed;
      logic [COORD_BITS-1:0] hit_x;
      logic [COORD_BITS-1:0] hit_y;
      logic                  inside_box;
   } rsp_item_type;

endpackage

// ----- rtl/core/point_to_box_border_hit_unit.sv -----
// Channel   Handshake          Payload                       Direction
// req_      start / busy       pbbh_pkg::req_item_type       in
// rsp_      rsp_valid strobe   pbbh_pkg::rsp_item_type       out
//
// One item is taken in every cycle; busy is high only while reset is high.
// Each result passes through registered stages A to E, the restoring divider with one
// quotient bit per stage, and the output register.
// Reset clears every valid bit, so items in flight are dropped.
// Results are shown for one cycle and the receiver cannot hold them off.
`include "point_to_box_border_hit_unit_assert.svh"

module point_to_box_border_hit_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pbbh_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output pbbh_pkg::rsp_item_type rsp_item
);

   localparam int CW   = pbbh_pkg::COORD_BITS;
   localparam int VW   = pbbh_pkg::VW;
   localparam int PW   = pbbh_pkg::PW;
   localparam int NUMW = pbbh_pkg::NUMW;
   localparam int NB   = pbbh_pkg::NB;

   typedef struct packed {
      logic [VW-1:0] dx;
      logic [VW-1:0] dy;
      logic [VW-1:0] w;
      logic [VW-1:0] h;
      logic [CW-1:0] ex;
      logic [CW-1:0] ey;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] bl;
      logic [CW-1:0] bt;
      logic [CW-1:0] br;
      logic [CW-1:0] bb;
      logic          in_box;
   } sa_type;

   typedef struct packed {
      logic [VW-1:0] dx;
      logic [VW-1:0] dy;
      logic [PW-1:0] pxh;
      logic [PW-1:0] pyw;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] bl;
      logic [CW-1:0] bt;
      logic [CW-1:0] br;
      logic [CW-1:0] bb;
      logic          in_box;
   } sb_type;

   typedef struct packed {
      pbbh_pkg::side_type side;
      logic               vert;
      logic [CW-1:0]      fix;
      logic               spec_en;
      logic [CW-1:0]      spec_val;
      logic               in_box;
   } tag_type;

   typedef struct packed {
      tag_type       tag;
      logic [VW-1:0] m1a;
      logic [VW-1:0] m1b;
      logic [VW-1:0] m2a;
      logic [VW-1:0] m2b;
      logic [VW-1:0] dv;
   } sc_type;

   typedef struct packed {
      tag_type       tag;
      logic [PW-1:0] p1;
      logic [PW-1:0] p2;
      logic [VW-1:0] dv;
   } sd_type;

   typedef struct packed {
      tag_type       tag;
      logic          neg;
      logic [CW-1:0] div_mag;
   } dtag_type;

   typedef struct packed {
      dtag_type      dtag;
      logic [NB-1:0] num_mag;
   } se_type;

   typedef struct packed {
      dtag_type      dtag;
      logic [CW-1:0] rem;
      logic [NB-1:0] nq;
   } dv_type;

   function automatic logic [VW-1:0] abs_v(input logic [VW-1:0] v);
      abs_v = v[VW-1] ? (~v + VW'(1)) : v;
   endfunction

   function automatic logic [CW-1:0] near_dist(input logic [CW-1:0] p,
                                               input logic [CW-1:0] lo,
                                               input logic [CW-1:0] hi);
      logic [VW-1:0] ma;
      logic [VW-1:0] mb;
      ma = abs_v({1'b0, p} - {1'b0, lo});
      mb = abs_v({1'b0, p} - {1'b0, hi});
      if (p >= lo && p <= hi) begin
         near_dist = '0;
      end else if (ma < mb) begin
         near_dist = ma[CW-1:0];
      end else begin
         near_dist = mb[CW-1:0];
      end
   endfunction

   logic          accept;
   logic [CW:0]   sum_x;
   logic [CW:0]   sum_y;

   logic          a_vld_ff;
   sa_type        a_ff;
   sa_type        a_in;
   logic          b_vld_ff;
   sb_type        b_ff;
   sb_type        b_in;
   logic          c_vld_ff;
   sc_type        c_ff;
   sc_type        c_in;
   logic          d_vld_ff;
   sd_type        d_ff;
   sd_type        d_in;
   logic          e_vld_ff;
   se_type        e_ff;
   se_type        e_in;
   logic [NUMW-1:0] e_num;
   logic [NUMW-1:0] e_abs;

   logic          dv_vld_ff [NB];
   dv_type        dv_ff     [NB];
   dv_type        dv_src    [NB];
   dv_type        dv_in     [NB];
   logic [CW:0]   dv_trial  [NB];
   logic [CW:0]   dv_diff   [NB];

   logic               rsp_valid_ff;
   pbbh_pkg::rsp_item_type rsp_item_ff;
   pbbh_pkg::rsp_item_type rsp_item_in;
   logic [CW-1:0]      f_q;
   logic [CW-1:0]      f_other;

   assign busy   = reset;
   assign accept = start && !busy;

   // Stage A: centre, offsets, box size and distance to the nearer border.
   always_comb begin
      sum_x     = {1'b0, req_item.box_left} + {1'b0, req_item.box_right};
      sum_y     = {1'b0, req_item.box_top} + {1'b0, req_item.box_bottom};
      a_in.dx   = {1'b0, sum_x[CW:1]} - {1'b0, req_item.point_x};
      a_in.dy   = {1'b0, sum_y[CW:1]} - {1'b0, req_item.point_y};
      a_in.w    = {1'b0, req_item.box_right} - {1'b0, req_item.box_left};
      a_in.h    = {1'b0, req_item.box_bottom} - {1'b0, req_item.box_top};
      a_in.ex   = near_dist(req_item.point_x, req_item.box_left, req_item.box_right);
      a_in.ey   = near_dist(req_item.point_y, req_item.box_top, req_item.box_bottom);
      a_in.px   = req_item.point_x;
      a_in.py   = req_item.point_y;
      a_in.bl   = req_item.box_left;
      a_in.bt   = req_item.box_top;
      a_in.br   = req_item.box_right;
      a_in.bb   = req_item.box_bottom;
      a_in.in_box = req_item.point_x >= req_item.box_left
                 && req_item.point_x <= req_item.box_right
                 && req_item.point_y >= req_item.box_top
                 && req_item.point_y <= req_item.box_bottom;
   end

   // Stage B: cross products that choose between vertical and horizontal sides.
   always_comb begin
      b_in.dx     = a_ff.dx;
      b_in.dy     = a_ff.dy;
      b_in.pxh    = PW'($signed({1'b0, a_ff.ex})) * PW'($signed(a_ff.h));
      b_in.pyw    = PW'($signed({1'b0, a_ff.ey})) * PW'($signed(a_ff.w));
      b_in.px     = a_ff.px;
      b_in.py     = a_ff.py;
      b_in.bl     = a_ff.bl;
      b_in.bt     = a_ff.bt;
      b_in.br     = a_ff.br;
      b_in.bb     = a_ff.bb;
      b_in.in_box = a_ff.in_box;
   end

   // Stage C: side, border coordinate, special cases and product operands.
   always_comb begin
      logic dx_pos;
      logic dy_pos;
      logic [CW-1:0] edge_sel;
      logic [CW-1:0] clamp_x;
      dx_pos = !b_ff.dx[VW-1] && b_ff.dx != '0;
      dy_pos = !b_ff.dy[VW-1] && b_ff.dy != '0;
      if (b_ff.px < b_ff.bl) begin
         clamp_x = b_ff.bl;
      end else if (b_ff.px > b_ff.br) begin
         clamp_x = b_ff.br;
      end else begin
         clamp_x = b_ff.px;
      end
      c_in.tag.in_box = b_ff.in_box;
      if ($signed(b_ff.pxh) > $signed(b_ff.pyw)) begin
         edge_sel            = dx_pos ? b_ff.bl : b_ff.br;
         c_in.tag.side       = dx_pos ? pbbh_pkg::SIDE_LEFT : pbbh_pkg::SIDE_RIGHT;
         c_in.tag.vert       = 1'b1;
         c_in.tag.fix        = edge_sel;
         c_in.tag.spec_en    = b_ff.dx == '0;
         c_in.tag.spec_val   = b_ff.py;
         c_in.m1a            = {1'b0, b_ff.py};
         c_in.m1b            = b_ff.dx;
         c_in.m2a            = {1'b0, edge_sel} - {1'b0, b_ff.px};
         c_in.m2b            = b_ff.dy;
         c_in.dv             = b_ff.dx;
      end else begin
         edge_sel            = dy_pos ? b_ff.bt : b_ff.bb;
         c_in.tag.side       = dy_pos ? pbbh_pkg::SIDE_TOP : pbbh_pkg::SIDE_BOTTOM;
         c_in.tag.vert       = 1'b0;
         c_in.tag.fix        = edge_sel;
         c_in.tag.spec_en    = b_ff.dy == '0 || b_ff.dx == '0;
         c_in.tag.spec_val   = (b_ff.dy == '0) ? clamp_x : b_ff.px;
         c_in.m1a            = {1'b0, b_ff.px};
         c_in.m1b            = b_ff.dy;
         c_in.m2a            = {1'b0, edge_sel} - {1'b0, b_ff.py};
         c_in.m2b            = b_ff.dx;
         c_in.dv             = b_ff.dy;
      end
      if (b_ff.in_box) begin
         c_in.tag.side     = pbbh_pkg::SIDE_LEFT;
         c_in.tag.vert     = 1'b1;
         c_in.tag.fix      = b_ff.px;
         c_in.tag.spec_en  = 1'b1;
         c_in.tag.spec_val = b_ff.py;
      end
   end

   // Stage D: the two products of the crossing numerator.
   always_comb begin
      d_in.tag = c_ff.tag;
      d_in.p1  = PW'($signed(c_ff.m1a)) * PW'($signed(c_ff.m1b));
      d_in.p2  = PW'($signed(c_ff.m2a)) * PW'($signed(c_ff.m2b));
      d_in.dv  = c_ff.dv;
   end

   // Stage E: numerator sum, signs and magnitudes for the divider.
   always_comb begin
      logic [VW-1:0] dv_abs;
      e_num  = NUMW'($signed(d_ff.p1)) + NUMW'($signed(d_ff.p2));
      e_abs  = e_num[NUMW-1] ? (~e_num + NUMW'(1)) : e_num;
      dv_abs = abs_v(d_ff.dv);
      e_in.dtag.tag     = d_ff.tag;
      e_in.dtag.neg     = e_num[NUMW-1] ^ d_ff.dv[VW-1];
      e_in.dtag.div_mag = dv_abs[CW-1:0];
      e_in.num_mag      = e_abs[NB-1:0];
   end

   // Restoring divider, one quotient bit per stage.
   always_comb begin
      dv_src[0].dtag = e_ff.dtag;
      dv_src[0].rem  = '0;
      dv_src[0].nq   = e_ff.num_mag;
      for (int k = 1; k < NB; k++) begin
         dv_src[k] = dv_ff[k-1];
      end
      for (int k = 0; k < NB; k++) begin
         dv_trial[k]   = {dv_src[k].rem, dv_src[k].nq[NB-1]};
         dv_diff[k]    = dv_trial[k] - {1'b0, dv_src[k].dtag.div_mag};
         dv_in[k].dtag = dv_src[k].dtag;
         if (dv_trial[k] >= {1'b0, dv_src[k].dtag.div_mag}) begin
            dv_in[k].rem = dv_diff[k][CW-1:0];
            dv_in[k].nq  = {dv_src[k].nq[NB-2:0], 1'b1};
         end else begin
            dv_in[k].rem = dv_trial[k][CW-1:0];
            dv_in[k].nq  = {dv_src[k].nq[NB-2:0], 1'b0};
         end
      end
   end

   // Output stage: sign of the quotient and placement of the coordinates.
   always_comb begin
      f_q     = dv_ff[NB-1].nq[CW-1:0];
      f_other = dv_ff[NB-1].dtag.tag.spec_en ? dv_ff[NB-1].dtag.tag.spec_val
              : (dv_ff[NB-1].dtag.neg ? (~f_q + CW'(1)) : f_q);
      rsp_item_in.side_crossed = dv_ff[NB-1].dtag.tag.side;
      rsp_item_in.inside_box   = dv_ff[NB-1].dtag.tag.in_box;
      if (dv_ff[NB-1].dtag.tag.vert) begin
         rsp_item_in.hit_x = dv_ff[NB-1].dtag.tag.fix;
         rsp_item_in.hit_y = f_other;
      end else begin
         rsp_item_in.hit_x = f_other;
         rsp_item_in.hit_y = dv_ff[NB-1].dtag.tag.fix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NB; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else begin
         a_vld_ff     <= accept;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         e_vld_ff     <= d_vld_ff;
         dv_vld_ff[0] <= e_vld_ff;
         for (int k = 1; k < NB; k++) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         rsp_valid_ff <= dv_vld_ff[NB-1];
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      for (int k = 0; k < NB; k++) begin
         dv_ff[k] <= dv_in[k];
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `PBBH_ASSERT_NEXT(a_accept_enters, clock, reset, accept, a_vld_ff)
   `PBBH_ASSERT_NOW(a_inside_left, clock, reset, rsp_valid && rsp_item.inside_box,
      rsp_item.side_crossed == pbbh_pkg::SIDE_LEFT)
   `PBBH_ASSERT_NOW(a_divisor_nonzero, clock, reset,
      e_vld_ff && !e_ff.dtag.tag.spec_en, e_ff.dtag.div_mag != '0)
   `PBBH_ASSERT_NOW(a_latency, clock, reset, rsp_valid_ff, $past(e_vld_ff, NB + 1))

endmodule

// ----- tb/border_hit_monitor.sv -----
module border_hit_monitor
   import pbbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_item_type expected_hits[$];

   // Distance from a coordinate to the nearer of two borders, zero between them.
   function automatic longint gap_to_span(longint p, longint lo, longint hi);
      longint a;
      longint b;
      a = (p >= lo) ? p - lo : lo - p;
      b = (p >= hi) ? p - hi : hi - p;
      if (p >= lo && p <= hi) begin
         return 0;
      end
      return (a < b) ? a : b;
   endfunction

   function automatic rsp_item_type predict_border_hit(req_item_type q);
      longint px, py, bl, bt, br, bb;
      longint cx, cy, dx, dy, w, h, ex, ey;
      longint bound, num, hx, hy;
      side_type side;
      rsp_item_type r;
      px = longint'(q.point_x);
      py = longint'(q.point_y);
      bl = longint'(q.box_left);
      bt = longint'(q.box_top);
      br = longint'(q.box_right);
      bb = longint'(q.box_bottom);
      cx = (bl + br) / 2;
      cy = (bt + bb) / 2;
      dx = cx - px;
      dy = cy - py;
      w  = br - bl;
      h  = bb - bt;
      ex = gap_to_span(px, bl, br);
      ey = gap_to_span(py, bt, bb);

      if (px >= bl && px <= br && py >= bt && py <= bb) begin
         r.side_crossed = SIDE_LEFT;
         r.hit_x        = q.point_x;
         r.hit_y        = q.point_y;
         r.inside_box   = 1'b1;
         return r;
      end

      if (ex * h > ey * w) begin
         side  = (dx > 0) ? SIDE_LEFT : SIDE_RIGHT;
         bound = (side == SIDE_LEFT) ? bl : br;
         hx    = bound;
         if (dx == 0) begin
            hy = py;
         end else begin
            num = py * dx + (bound - px) * dy;
            hy  = num / dx;
         end
      end else begin
         side  = (dy > 0) ? SIDE_TOP : SIDE_BOTTOM;
         bound = (side == SIDE_TOP) ? bt : bb;
         hy    = bound;
         if (dy == 0) begin
            if (px < bl) begin
               hx = bl;
            end else if (px > br) begin
               hx = br;
            end else begin
               hx = px;
            end
         end else if (dx == 0) begin
            hx = px;
         end else begin
            num = px * dy + (bound - py) * dx;
            hx  = num / dy;
         end
      end

      r.side_crossed = side;
      r.hit_x        = hx[COORD_BITS-1:0];
      r.hit_y        = hy[COORD_BITS-1:0];
      r.inside_box   = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         expected_hits.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_hits.size() == 0) begin
               $error("result with no item outstanding: side_crossed %0d hit_x %0d hit_y %0d",
                      rsp_item.side_crossed, rsp_item.hit_x, rsp_item.hit_y);
               fail_count++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_item.side_crossed !== want.side_crossed) begin
                  $error("side_crossed: expected %0d, actual %0d",
                         want.side_crossed, rsp_item.side_crossed);
                  fail_count++;
               end
               if (rsp_item.hit_x !== want.hit_x) begin
                  $error("hit_x: expected %0d, actual %0d", want.hit_x, rsp_item.hit_x);
                  fail_count++;
               end
               if (rsp_item.hit_y !== want.hit_y) begin
                  $error("hit_y: expected %0d, actual %0d", want.hit_y, rsp_item.hit_y);
                  fail_count++;
               end
               if (rsp_item.inside_box !== want.inside_box) begin
                  $error("inside_box: expected %0d, actual %0d",
                         want.inside_box, rsp_item.inside_box);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_hits.push_back(predict_border_hit(req_item));
         end
      end
      pending = expected_hits.size();
   end

endmodule

// ----- tb/tb.sv -----
module tb;
   import pbbh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int RANDOM_ITEMS = 1700;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending;
   int           burst_left;

   point_to_box_border_hit_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   border_hit_monitor u_hit_monitor (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic req_item_type make_query(int px, int py, int l, int t, int r, int b);
      req_item_type q;
      q.point_x    = px[COORD_BITS-1:0];
      q.point_y    = py[COORD_BITS-1:0];
      q.box_left   = l[COORD_BITS-1:0];
      q.box_top    = t[COORD_BITS-1:0];
      q.box_right  = r[COORD_BITS-1:0];
      q.box_bottom = b[COORD_BITS-1:0];
      return q;
   endfunction

   function automatic int special_coord();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 1;
         2:       return COORD_MAX - 1;
         default: return COORD_MAX;
      endcase
   endfunction

   function automatic req_item_type ordered_box(req_item_type q);
      logic [COORD_BITS-1:0] swap;
      if (q.box_left > q.box_right) begin
         swap        = q.box_left;
         q.box_left  = q.box_right;
         q.box_right = swap;
      end
      if (q.box_top > q.box_bottom) begin
         swap         = q.box_top;
         q.box_top    = q.box_bottom;
         q.box_bottom = swap;
      end
      return q;
   endfunction

   function automatic req_item_type random_query();
      req_item_type q;
      int kind;
      int lo;
      q = make_query($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
         end
         2, 3: q = ordered_box(q);
         4: begin
            lo = $urandom_range(0, COORD_MAX);
            q.box_left  = lo[COORD_BITS-1:0];
            lo = lo + $urandom_range(0, 15);
            q.box_right = (lo > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : lo[COORD_BITS-1:0];
            lo = $urandom_range(0, COORD_MAX);
            q.box_top   = lo[COORD_BITS-1:0];
            lo = lo + $urandom_range(0, 15);
            q.box_bottom = (lo > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : lo[COORD_BITS-1:0];
         end
         5: begin
            q = ordered_box(q);
            q.point_x = COORD_BITS'($urandom_range(q.box_left, q.box_right));
            q.point_y = COORD_BITS'($urandom_range(q.box_top, q.box_bottom));
         end
         6: begin
            q = ordered_box(q);
            if ($urandom_range(0, 1)) begin
               lo = (int'(q.box_left) + int'(q.box_right)) / 2;
               q.point_x = lo[COORD_BITS-1:0];
            end else begin
               lo = (int'(q.box_top) + int'(q.box_bottom)) / 2;
               q.point_y = lo[COORD_BITS-1:0];
            end
         end
         7: begin
            q = ordered_box(q);
            if ($urandom_range(0, 1)) begin
               q.box_bottom = q.box_top;
               if ($urandom_range(0, 1)) q.point_y = q.box_top;
            end else begin
               q.box_right = q.box_left;
               if ($urandom_range(0, 1)) q.point_x = q.box_left;
            end
         end
         8: begin
            q = ordered_box(q);
            case ($urandom_range(0, 3))
               0:       q.point_x = q.box_left - 1'b1;
               1:       q.point_x = q.box_right + 1'b1;
               2:       q.point_y = q.box_top - 1'b1;
               default: q.point_y = q.box_bottom + 1'b1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1)) q.point_x    = COORD_BITS'(special_coord());
            if ($urandom_range(0, 1)) q.point_y    = COORD_BITS'(special_coord());
            if ($urandom_range(0, 1)) q.box_left   = COORD_BITS'(special_coord());
            if ($urandom_range(0, 1)) q.box_top    = COORD_BITS'(special_coord());
            if ($urandom_range(0, 1)) q.box_right  = COORD_BITS'(special_coord());
            if ($urandom_range(0, 1)) q.box_bottom = COORD_BITS'(special_coord());
            if ($urandom_range(0, 2) != 0) q = ordered_box(q);
         end
      endcase
      return q;
   endfunction

   // Called and returning at a falling edge; start stays high across back-to-back items.
   task automatic send_item(req_item_type item);
      int gap;
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            burst_left = $urandom_range(20, 120);
            gap = 0;
         end else if (roll < 55) begin
            gap = 0;
         end else if (roll < 90) begin
            gap = $urandom_range(1, 3);
         end else if (roll < 97) begin
            gap = $urandom_range(4, 12);
         end else begin
            gap = $urandom_range(20, 60);
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin
      req_item_type directed_items[$];
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      burst_left = 0;

      directed_items.push_back(make_query(0, 0, 0, 0, 0, 0));
      directed_items.push_back(make_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                          COORD_MAX, COORD_MAX));
      directed_items.push_back(make_query(0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      directed_items.push_back(make_query(COORD_MAX, COORD_MAX, 0, 0, 0, 0));
      directed_items.push_back(make_query(COORD_MAX, 0, 0, COORD_MAX, 0, COORD_MAX));
      directed_items.push_back(make_query(100, 100, 50, 50, 200, 200));
      directed_items.push_back(make_query(0, 500, 1000, 400, 2000, 600));
      directed_items.push_back(make_query(COORD_MAX, 500, 1000, 400, 2000, 600));
      directed_items.push_back(make_query(1500, 0, 1000, 400, 2000, 600));
      directed_items.push_back(make_query(1500, COORD_MAX, 1000, 400, 2000, 600));
      directed_items.push_back(make_query(1200, 0, 1000, 400, 2000, 600));
      directed_items.push_back(make_query(0, 500, 1000, 500, 2000, 500));
      directed_items.push_back(make_query(COORD_MAX, 500, 1000, 500, 2000, 500));
      directed_items.push_back(make_query(1500, 500, 1000, 500, 2000, 500));
      directed_items.push_back(make_query(0, 500, 1000, 400, 1000, 600));
      directed_items.push_back(make_query(0, 0, 2000, 600, 1000, 400));
      directed_items.push_back(make_query(2000, 4000, 3000, 100, 1000, 200));
      directed_items.push_back(make_query(1000, 400, 1000, 400, 2000, 600));
      directed_items.push_back(make_query(999, 399, 1000, 400, 2000, 600));
      directed_items.push_back(make_query(2, COORD_MAX, 1, 1, 4, 4));
      directed_items.push_back(make_query(0, 0, 100, 100, 200, 200));
      directed_items.push_back(make_query(COORD_MAX, 0, 0, 100, 10, 4000));
      directed_items.push_back(make_query(3000, 3000, 4000, 10, 100, 4090));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_items[i]) begin
         send_item(directed_items[i]);
      end
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_item(random_query());
         if ($urandom_range(0, 299) == 0) begin
            drain_results();
         end
      end
      drain_results();
      repeat (40) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pbbh_pkg.sv
rtl/core/point_to_box_border_hit_unit.sv
tb/border_hit_monitor.sv
tb/tb.sv
